// ----- src/i2cm_pkg.sv -----
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types, phase codes and line drive decode for the i2c register master
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // command kinds as classified by the front end
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_BEGIN_W = 2'd1;
  localparam logic [1:0] CMD_BEGIN_R = 2'd2;
  localparam logic [1:0] CMD_DATA    = 2'd3;

  // phase step codes: group in bits 5:3, minor step in bits 2:0
  localparam logic [5:0] PH_IDLE = 6'd0;
  localparam logic [5:0] PH_WAIT = 6'd1;
  localparam logic [5:0] PH_P0   = 6'd2;
  localparam logic [5:0] PH_P1   = 6'd3;
  localparam logic [5:0] PH_P2   = 6'd4;

  localparam logic [2:0] G_NONE   = 3'd0;
  localparam logic [2:0] G_START1 = 3'd1;
  localparam logic [2:0] G_ADDRW  = 3'd2;
  localparam logic [2:0] G_REG    = 3'd3;
  localparam logic [2:0] G_START2 = 3'd4;
  localparam logic [2:0] G_ADDRR  = 3'd5;
  localparam logic [2:0] G_DATAW  = 3'd6;
  localparam logic [2:0] G_RECV   = 3'd7;

  // start status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam int InDataW  = 32;
  localparam int OutDataW = 24;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] target_address;
    logic [7:0] register_index;
    logic [7:0] byte_count;
    logic [7:0] write_byte;
    logic       sda_in;
  } item_t;

  // line drive on entering a phase; drive[1] scl, drive[0] sda
  function automatic logic [1:0] enter_drive(input logic [5:0] p, input logic [1:0] drive,
                                             input logic [7:0] bytes_left,
                                             input logic [7:0] shift_byte);
    logic [2:0] g;
    logic [2:0] m;
    logic [1:0] d;
    g = p[5:3];
    m = p[2:0];
    d = drive;
    if (g == G_START1 || g == G_START2) begin
      if (m == 3'd0) d[0] = 1'b1;
      else if (m == 3'd1) d[1] = 1'b1;
      else if (m == 3'd2) d[0] = 1'b0;
      else d[1] = 1'b0;
    end else if (g == G_RECV) begin
      if (m == 3'd0) d = 2'b11;
      else if (m == 3'd1 || m == 3'd4) d[1] = 1'b0;
      else if (m == 3'd2) d[0] = (bytes_left == 8'd1);
      else d[1] = 1'b1;
    end else if (g != G_NONE) begin
      if (m == 3'd0) begin
        d[1] = 1'b0;
        d[0] = shift_byte[7];
      end else if (m == 3'd1 || m == 3'd4) d[1] = 1'b1;
      else if (m == 3'd2) d[1] = 1'b0;
      else d[0] = 1'b1;
    end else begin
      if (p == PH_P0) d[0] = 1'b0;
      else if (p == PH_P1) d[1] = 1'b1;
      else if (p == PH_P2) d[0] = 1'b1;
    end
    return d;
  endfunction

endpackage

// ----- src/i2cm_front.sv -----
// ----------------------------------------------------------------------------
// i2cm_front
// accepts input transactions, classifies them and holds them in a two-entry queue
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [i2cm_pkg::InDataW-1:0]  in_tdata,
  input  logic [1:0]                    in_tuser,
  output logic                          q_valid,
  input  logic                          q_ready,
  output i2cm_pkg::item_t               q_item
);
  import i2cm_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  item_t      cls;

  // classify: only the fields a command kind uses are kept, plus sda_in for every kind
  always_comb begin
    cls                = '0;
    cls.kind           = in_tuser;
    cls.sda_in         = in_tdata[31];
    case (in_tuser)
      CMD_BEGIN_W, CMD_BEGIN_R: begin
        cls.target_address = in_tdata[6:0];
        cls.register_index = in_tdata[14:7];
        cls.byte_count     = in_tdata[22:15];
      end
      CMD_DATA: begin
        cls.write_byte = in_tdata[30:23];
      end
      default: begin
        cls.kind = CMD_TICK;
      end
    endcase
  end

  assign in_tready = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ----- src/i2cm_engine.sv -----
// ----------------------------------------------------------------------------
// i2cm_engine
// bus phase sequencer with a registered result stage
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [9:0]                    phase_ticks,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  i2cm_pkg::item_t               q_item,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [i2cm_pkg::OutDataW-1:0] out_tdata,
  output logic                          out_tlast
);
  import i2cm_pkg::*;

  logic [5:0] ps_r, ps_nxt;
  logic [3:0] bc_r, bc_nxt;
  logic [7:0] sb_r, sb_nxt;
  logic [7:0] bl_r, bl_nxt;
  logic [6:0] sa_r, sa_nxt;
  logic [7:0] sr_r, sr_nxt;
  logic       rm_r, rm_nxt;
  logic [9:0] tc_r, tc_nxt;
  logic [1:0] ld_r, ld_nxt;
  logic [2:0] sf_r, sf_nxt;

  logic                vld_r, vld_nxt;
  logic [OutDataW-1:0] data_r, data_nxt;
  logic                last_r, last_nxt;

  logic       pop;
  logic [9:0] limit;
  logic [2:0] g, m;
  logic       do_ent;
  logic [5:0] tgt;
  logic [7:0] rdata;
  logic       rvalid, rlast, done;
  logic       sda;

  assign q_ready = !vld_r || out_tready;
  assign pop     = q_valid && q_ready;
  assign limit   = (phase_ticks == 10'd0) ? 10'd1 : phase_ticks;
  assign g       = ps_r[5:3];
  assign m       = ps_r[2:0];
  assign sda     = q_item.sda_in;

  always_comb begin
    ps_nxt = ps_r; bc_nxt = bc_r; sb_nxt = sb_r; bl_nxt = bl_r;
    sa_nxt = sa_r; sr_nxt = sr_r; rm_nxt = rm_r; tc_nxt = tc_r;
    ld_nxt = ld_r; sf_nxt = sf_r;
    do_ent = 1'b0;
    tgt    = PH_IDLE;
    rdata  = 8'd0;
    rvalid = 1'b0;
    rlast  = 1'b0;
    done   = 1'b0;
    case (q_item.kind)
      CMD_BEGIN_W, CMD_BEGIN_R: begin
        if (ps_r == PH_IDLE) begin
          sa_nxt = q_item.target_address;
          sr_nxt = q_item.register_index;
          bl_nxt = q_item.byte_count;
          rm_nxt = (q_item.kind == CMD_BEGIN_R);
          sf_nxt = 3'd0;
          do_ent = 1'b1;
          tgt    = {G_START1, 3'd0};
        end
      end
      CMD_DATA: begin
        if (ps_r == PH_WAIT) begin
          bl_nxt = bl_r - 8'd1;
          sb_nxt = q_item.write_byte;
          bc_nxt = 4'd0;
          do_ent = 1'b1;
          tgt    = {G_DATAW, 3'd0};
        end
      end
      default: begin
        if (ps_r != PH_IDLE && ps_r != PH_WAIT) begin
          if ({1'b0, tc_r} + 11'd1 < {1'b0, limit}) begin
            tc_nxt = tc_r + 10'd1;
          end else if (g == G_START1 || g == G_START2) begin
            if ((m == 3'd1 && !sda) || m == 3'd3) begin
              if (m == 3'd1) sf_nxt[1:0] = ST_BUSY;
              else if (sda) sf_nxt[1:0] = ST_ERR;
              sb_nxt = {sa_r, (g == G_START2)};
              bc_nxt = 4'd0;
              do_ent = 1'b1;
              tgt    = {(g == G_START1) ? G_ADDRW : G_ADDRR, 3'd0};
            end else begin
              do_ent = 1'b1;
              tgt    = ps_r + 6'd1;
            end
          end else if (g == G_RECV) begin
            do_ent = 1'b1;
            if (m == 3'd0) begin
              sb_nxt = {sb_r[6:0], sda};
              bc_nxt = bc_r + 4'd1;
              tgt    = ps_r + 6'd1;
            end else if (m == 3'd1) begin
              tgt = bc_r[3] ? {G_RECV, 3'd2} : {G_RECV, 3'd0};
            end else if (m < 3'd4) begin
              tgt = ps_r + 6'd1;
            end else begin
              rdata  = sb_r;
              rvalid = 1'b1;
              rlast  = (bl_r == 8'd1);
              bl_nxt = bl_r - 8'd1;
              if (bl_nxt != 8'd0) begin
                sb_nxt = 8'd0;
                bc_nxt = 4'd0;
                tgt    = {G_RECV, 3'd0};
              end else begin
                tgt = PH_P0;
              end
            end
          end else if (g != G_NONE) begin
            if (m == 3'd0 || m == 3'd1 || m == 3'd3) begin
              do_ent = 1'b1;
              tgt    = ps_r + 6'd1;
            end else if (m == 3'd2) begin
              sb_nxt = {sb_r[6:0], 1'b0};
              bc_nxt = bc_r + 4'd1;
              do_ent = 1'b1;
              tgt    = bc_nxt[3] ? {g, 3'd3} : {g, 3'd0};
            end else begin
              // acknowledge slot ends: sample ack, pull scl low
              sf_nxt[2] = !sda;
              ld_nxt[1] = 1'b0;
              do_ent    = 1'b1;
              if (g == G_ADDRW) begin
                sb_nxt = sr_r;
                bc_nxt = 4'd0;
                tgt    = {G_REG, 3'd0};
              end else if (g == G_REG && rm_r) begin
                tgt = {G_START2, 3'd0};
              end else if (g == G_ADDRR) begin
                if (bl_r != 8'd0) begin
                  sb_nxt = 8'd0;
                  bc_nxt = 4'd0;
                  tgt    = {G_RECV, 3'd0};
                end else begin
                  tgt = PH_P0;
                end
              end else if (bl_r != 8'd0) begin
                do_ent = 1'b0;
                ps_nxt = PH_WAIT;
                tc_nxt = 10'd0;
              end else begin
                tgt = PH_P0;
              end
            end
          end else begin
            if (ps_r == PH_P0 || ps_r == PH_P1) begin
              do_ent = 1'b1;
              tgt    = ps_r + 6'd1;
            end else if (ps_r == PH_P2) begin
              do_ent = 1'b1;
              tgt    = PH_IDLE;
              done   = 1'b1;
            end
          end
        end
      end
    endcase
    if (do_ent) begin
      ps_nxt = tgt;
      tc_nxt = 10'd0;
      ld_nxt = enter_drive(tgt, ld_nxt, bl_nxt, sb_nxt);
    end
  end

  // result word, highest bit first
  always_comb begin
    vld_nxt  = vld_r;
    data_nxt = data_r;
    last_nxt = last_r;
    if (pop) begin
      vld_nxt  = 1'b1;
      data_nxt = {7'd0, done, (ps_nxt != PH_IDLE), sf_nxt[1:0], sf_nxt[2],
                  (ps_nxt == PH_WAIT), rvalid, rdata, ld_nxt[0], ld_nxt[1]};
      last_nxt = rlast;
    end else if (out_tready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r  <= PH_IDLE;
      bc_r  <= 4'd0;
      sb_r  <= 8'd0;
      bl_r  <= 8'd0;
      sa_r  <= 7'd0;
      sr_r  <= 8'd0;
      rm_r  <= 1'b0;
      tc_r  <= 10'd0;
      ld_r  <= 2'b11;
      sf_r  <= 3'd0;
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      if (pop) begin
        ps_r <= ps_nxt;
        bc_r <= bc_nxt;
        sb_r <= sb_nxt;
        bl_r <= bl_nxt;
        sa_r <= sa_nxt;
        sr_r <= sr_nxt;
        rm_r <= rm_nxt;
        tc_r <= tc_nxt;
        ld_r <= ld_nxt;
        sf_r <= sf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule

// ----- src/i2c_master_register_access_top.sv -----
// ----------------------------------------------------------------------------
// i2c_master_register_access_top
// i2c master for register writes and reads, advancing the bus one tick per tick command
// ----------------------------------------------------------------------------
// usage
//   in_* carries one command per transaction: tick, begin write, begin read
//   or supply write byte (in_tuser). tick commands come from a prescaler and
//   advance the bus by one tick; each phase lasts cfg phase_ticks ticks.
//   out_* returns exactly one result transaction per command: scl/sda drive,
//   received byte with read_valid (out_tlast marks the nacked last byte),
//   need_byte, ack of the last sent byte, start status, busy and done.
//   cfg_wr_en / cfg_wr_data write phase_ticks (reset 1, zero acts as one);
//   write it only while no command is in flight.
// timing
//   a command lands in a two-entry queue; the engine takes one per cycle while
//   out_tready does not stall it, and registers its result.
//   sustained rate is one command per cycle while out_tready stays high.
// reset and stall
//   rst_n (sync, active low) empties the queue and result stage, idles the
//   engine with both lines released. when out_tready is low the result
//   holds, the engine stops and the queue absorbs up to two more commands.
// ----------------------------------------------------------------------------
module i2c_master_register_access_top (
  input  logic                          clk,
  input  logic                          rst_n,
  // tdata: target_address[6:0], register_index[14:7], byte_count[22:15],
  //        write_byte[30:23], sda_in[31]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [i2cm_pkg::InDataW-1:0]  in_tdata,
  // tuser: op[1:0]
  input  logic [1:0]                    in_tuser,
  // tdata: scl_out[0], sda_out[1], read_data[9:2], read_valid[10],
  //        need_byte[11], ack_seen[12], start_status[14:13], busy_res[15],
  //        done_res[16], zero fill[23:17]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [i2cm_pkg::OutDataW-1:0] out_tdata,
  // tlast: read_last
  output logic                          out_tlast,
  input  logic                          cfg_wr_en,
  input  logic [9:0]                    cfg_wr_data
);
  import i2cm_pkg::*;

  logic [9:0] phase_ticks_r, phase_ticks_nxt;
  logic       q_valid;
  logic       q_ready;
  item_t      q_item;

  // phase length register
  assign phase_ticks_nxt = cfg_wr_en ? cfg_wr_data : phase_ticks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= 10'd1;
    end else begin
      phase_ticks_r <= phase_ticks_nxt;
    end
  end

  // front end: classify and queue
  i2cm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  // back end: bus sequencer and result register
  i2cm_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .phase_ticks (phase_ticks_r),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

// ----- src/i2cm_checker.sv -----
// ----------------------------------------------------------------------------
// i2cm_checker
// port-level checks on the result channel of the i2c register master
// ----------------------------------------------------------------------------
module i2cm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [i2cm_pkg::OutDataW-1:0] out_tdata,
  input logic                          out_tlast
);
  import i2cm_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a finished transaction leaves the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[16] |-> !out_tdata[15] && !out_tdata[10])
    else $error("done reported while busy");

  // a byte request only inside a transaction
  a_need_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[11] |-> out_tdata[15] && !out_tdata[10])
    else $error("byte request outside a transaction");

  // last marker only with a received byte
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[10])
    else $error("read_last without read_valid");

  // start status never takes the unused code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[14:13] == ST_OK || out_tdata[14:13] == ST_BUSY ||
                   out_tdata[14:13] == ST_ERR)
    else $error("bad start status");

endmodule

bind i2c_master_register_access_top i2cm_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/sv/tb_i2c_master_register_access_top.sv -----
// ----------------------------------------------------------------------------
// tb_i2c_master_register_access_top
// self-checking bench for the i2c register master
// ----------------------------------------------------------------------------
// a cycle-free model of the bus engine runs on every accepted command and
// queues the result transaction it should produce; the checker compares each
// returned result field by field against the oldest queued one. directed
// tests cover idle commands, start faults, the write byte handoff, empty
// reads, long phases and back-pressure; random register writes and reads
// follow under three idling mixes, and the run ends on a 255-byte write.
// ----------------------------------------------------------------------------
module tb_i2c_master_register_access_top;
  import i2cm_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic [1:0]          in_tuser = CMD_TICK;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;
  logic                cfg_wr_en = 1'b0;
  logic [9:0]          cfg_wr_data = '0;

  i2c_master_register_access_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #10 clk = ~clk;

  // what one result transaction carries
  typedef struct {
    logic       scl;
    logic       sda;
    logic [7:0] rdata;
    logic       rvalid;
    logic       rlast;
    logic       need_byte;
    logic       ack;
    logic [1:0] start_st;
    logic       busy;
    logic       done;
  } bus_report_t;

  bus_report_t pending_reports[$];

  // bus engine state as the bench tracks it
  logic [5:0] bus_phase    = PH_IDLE;
  logic [3:0] bit_idx      = '0;
  logic [7:0] shift_reg    = '0;
  logic [7:0] bytes_remain = '0;
  logic [6:0] dev_addr     = '0;
  logic [7:0] reg_byte     = '0;
  logic       is_read      = 1'b0;
  logic [9:0] tick_cnt     = '0;
  logic       scl_drv      = 1'b1;
  logic       sda_drv      = 1'b1;
  logic [1:0] start_code   = ST_OK;
  logic       got_ack      = 1'b0;
  logic [9:0] phase_len    = 10'd1;

  // per-command events
  logic [7:0] ev_rdata;
  logic       ev_rvalid;
  logic       ev_rlast;
  logic       ev_done;

  int send_idle_pct = 23;
  int recv_idle_pct = 48;
  int hold_target = 0;
  int hold_served = 0;
  int err_cnt = 0;
  int n_items = 0;
  int n_results = 0;
  int n_stops = 0;
  int n_read_bytes = 0;

  // ---------------------------------------------------------------- model

  // line changes happen when a phase is entered
  function automatic void enter_phase(input logic [5:0] p);
    logic [2:0] g;
    logic [2:0] m;
    g = p[5:3];
    m = p[2:0];
    bus_phase = p;
    tick_cnt = '0;
    if (g == G_START1 || g == G_START2) begin
      case (m)
        3'd0: sda_drv = 1'b1;
        3'd1: scl_drv = 1'b1;
        3'd2: sda_drv = 1'b0;
        default: scl_drv = 1'b0;
      endcase
    end else if (g == G_RECV) begin
      case (m)
        3'd0: begin
          scl_drv = 1'b1;
          sda_drv = 1'b1;
        end
        3'd1, 3'd4: scl_drv = 1'b0;
        3'd2: sda_drv = (bytes_remain == 8'd1);  // nack only the last byte
        default: scl_drv = 1'b1;
      endcase
    end else if (g != G_NONE) begin
      case (m)
        3'd0: begin
          scl_drv = 1'b0;
          sda_drv = shift_reg[7];
        end
        3'd1, 3'd4: scl_drv = 1'b1;
        3'd2: scl_drv = 1'b0;
        default: sda_drv = 1'b1;  // release for the ack slot
      endcase
    end else begin
      case (p)
        PH_P0: sda_drv = 1'b0;
        PH_P1: scl_drv = 1'b1;
        PH_P2: sda_drv = 1'b1;
        default: ;
      endcase
    end
  endfunction

  function automatic void load_byte(input logic [2:0] g, input logic [7:0] b);
    shift_reg = b;
    bit_idx = '0;
    enter_phase({g, 3'd0});
  endfunction

  function automatic void load_recv();
    shift_reg = '0;
    bit_idx = '0;
    enter_phase({G_RECV, 3'd0});
  endfunction

  function automatic void header_after_start(input logic [2:0] g);
    if (g == G_START1) load_byte(G_ADDRW, {dev_addr, 1'b0});
    else load_byte(G_ADDRR, {dev_addr, 1'b1});
  endfunction

  // last tick of a phase: sample sda and move on
  function automatic void end_phase(input logic sd);
    logic [2:0] g;
    logic [2:0] m;
    g = bus_phase[5:3];
    m = bus_phase[2:0];
    if (g == G_START1 || g == G_START2) begin
      if (m == 3'd1 && !sd) begin
        // line held low: bus busy, skip straight to the address
        start_code = ST_BUSY;
        header_after_start(g);
      end else if (m == 3'd3) begin
        if (sd) start_code = ST_ERR;
        header_after_start(g);
      end else begin
        enter_phase(bus_phase + 6'd1);
      end
    end else if (g == G_RECV) begin
      case (m)
        3'd0: begin
          shift_reg = {shift_reg[6:0], sd};
          bit_idx = bit_idx + 4'd1;
          enter_phase(bus_phase + 6'd1);
        end
        3'd1: enter_phase(bit_idx >= 4'd8 ? {G_RECV, 3'd2} : {G_RECV, 3'd0});
        3'd2, 3'd3: enter_phase(bus_phase + 6'd1);
        default: begin
          ev_rdata = shift_reg;
          ev_rvalid = 1'b1;
          ev_rlast = (bytes_remain == 8'd1);
          bytes_remain = bytes_remain - 8'd1;
          if (bytes_remain != 8'd0) load_recv();
          else enter_phase(PH_P0);
        end
      endcase
    end else if (g != G_NONE) begin
      case (m)
        3'd0, 3'd1, 3'd3: enter_phase(bus_phase + 6'd1);
        3'd2: begin
          shift_reg = {shift_reg[6:0], 1'b0};
          bit_idx = bit_idx + 4'd1;
          enter_phase(bit_idx >= 4'd8 ? {g, 3'd3} : {g, 3'd0});
        end
        default: begin
          got_ack = !sd;
          scl_drv = 1'b0;
          if (g == G_ADDRW) begin
            load_byte(G_REG, reg_byte);
          end else if (g == G_REG && is_read) begin
            enter_phase({G_START2, 3'd0});
          end else if (g == G_ADDRR) begin
            if (bytes_remain != 8'd0) load_recv();
            else enter_phase(PH_P0);
          end else if (bytes_remain != 8'd0) begin
            // hold the bus until the next write byte arrives
            bus_phase = PH_WAIT;
            tick_cnt = '0;
          end else begin
            enter_phase(PH_P0);
          end
        end
      endcase
    end else if (bus_phase == PH_P0 || bus_phase == PH_P1) begin
      enter_phase(bus_phase + 6'd1);
    end else if (bus_phase == PH_P2) begin
      enter_phase(PH_IDLE);
      ev_done = 1'b1;
    end
  endfunction

  // one accepted command: update engine state and queue its result
  function automatic void step_bus_engine(input logic [1:0] op, input logic [6:0] ta,
                                          input logic [7:0] ri, input logic [7:0] bc,
                                          input logic [7:0] wb, input logic sd);
    bus_report_t r;
    int lim;
    ev_rdata = '0;
    ev_rvalid = 1'b0;
    ev_rlast = 1'b0;
    ev_done = 1'b0;
    lim = (phase_len == 10'd0) ? 1 : int'(phase_len);
    case (op)
      CMD_BEGIN_W, CMD_BEGIN_R: begin
        if (bus_phase == PH_IDLE) begin
          dev_addr = ta;
          reg_byte = ri;
          bytes_remain = bc;
          is_read = (op == CMD_BEGIN_R);
          start_code = ST_OK;
          got_ack = 1'b0;
          enter_phase({G_START1, 3'd0});
        end
      end
      CMD_DATA: begin
        if (bus_phase == PH_WAIT) begin
          bytes_remain = bytes_remain - 8'd1;
          load_byte(G_DATAW, wb);
        end
      end
      default: begin
        if (bus_phase != PH_IDLE && bus_phase != PH_WAIT) begin
          if (int'(tick_cnt) + 1 >= lim) end_phase(sd);
          else tick_cnt = tick_cnt + 10'd1;
        end
      end
    endcase
    r.scl = scl_drv;
    r.sda = sda_drv;
    r.rdata = ev_rdata;
    r.rvalid = ev_rvalid;
    r.rlast = ev_rlast;
    r.need_byte = (bus_phase == PH_WAIT);
    r.ack = got_ack;
    r.start_st = start_code;
    r.busy = (bus_phase != PH_IDLE);
    r.done = ev_done;
    pending_reports.push_back(r);
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic string show_report(input bus_report_t r);
    return $sformatf({"scl=%b sda=%b data=%h valid=%b last=%b need=%b ack=%b ",
                      "start=%0d busy=%b done=%b"},
                     r.scl, r.sda, r.rdata, r.rvalid, r.rlast, r.need_byte, r.ack,
                     r.start_st, r.busy, r.done);
  endfunction

  function automatic void note_error(input string what);
    if (err_cnt < 10) $display("[%0t] %s", $time, what);
    err_cnt++;
  endfunction

  always @(posedge clk) begin : result_check
    bus_report_t want;
    bus_report_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.scl = out_tdata[0];
      got.sda = out_tdata[1];
      got.rdata = out_tdata[9:2];
      got.rvalid = out_tdata[10];
      got.need_byte = out_tdata[11];
      got.ack = out_tdata[12];
      got.start_st = out_tdata[14:13];
      got.busy = out_tdata[15];
      got.done = out_tdata[16];
      got.rlast = out_tlast;
      n_results++;
      if (got.done === 1'b1) n_stops++;
      if (got.rvalid === 1'b1) n_read_bytes++;
      if (pending_reports.size() == 0) begin
        note_error({"result with nothing pending: ", show_report(got)});
      end else begin
        want = pending_reports.pop_front();
        if (got.scl !== want.scl || got.sda !== want.sda || got.rdata !== want.rdata ||
            got.rvalid !== want.rvalid || got.rlast !== want.rlast ||
            got.need_byte !== want.need_byte || got.ack !== want.ack ||
            got.start_st !== want.start_st || got.busy !== want.busy ||
            got.done !== want.done)
          note_error({"result differs\n  want ", show_report(want),
                      "\n  got  ", show_report(got)});
      end
    end
  end

  // receiver: random stalls, plus long hold-offs requested by a test
  always @(negedge clk) begin
    if (hold_served < hold_target) begin
      out_tready <= 1'b0;
      hold_served <= hold_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- driving

  // one command transaction; called and returns at a falling edge
  task automatic send_cmd(input logic [1:0] op, input logic [6:0] ta, input logic [7:0] ri,
                          input logic [7:0] bc, input logic [7:0] wb, input logic sd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {sd, wb, bc, ri, ta};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    step_bus_engine(op, ta, ri, bc, wb, sd);
    n_items++;
    @(negedge clk);
  endtask

  // unused fields of a tick carry noise
  task automatic send_tick(input logic sd);
    send_cmd(CMD_TICK, 7'($urandom_range(127)), 8'($urandom_range(255)),
             8'($urandom_range(255)), 8'($urandom_range(255)), sd);
  endtask

  // sda as a target would present it, with occasional faults
  function automatic logic pick_sda();
    logic [2:0] g;
    logic [2:0] m;
    g = bus_phase[5:3];
    m = bus_phase[2:0];
    if ($urandom_range(99) < 10) return $urandom_range(1) == 1;
    if (g == G_RECV && m == 3'd0) return $urandom_range(1) == 1;
    if (g != G_NONE && g != G_START1 && g != G_START2 && g != G_RECV && m == 3'd4)
      return $urandom_range(3) == 0;  // mostly ack
    return sda_drv;
  endfunction

  // walk the current bus transaction until idle or the item budget runs out
  task automatic drive_bus(input int max_items);
    int sent;
    int r;
    sent = 0;
    while (bus_phase != PH_IDLE && sent < max_items) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_cmd(2'($urandom_range(3)), 7'($urandom_range(127)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end else if (bus_phase == PH_WAIT) begin
        if (r < 12) send_tick(1'($urandom_range(1)));
        else send_cmd(CMD_DATA, 7'($urandom_range(127)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
      end else begin
        send_tick(pick_sda());
      end
      sent++;
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  // only with nothing in flight
  task automatic write_phase_len(input logic [9:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    phase_len = v;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_idle_commands();
    send_tick(1'b0);
    send_tick(1'b1);
    send_cmd(CMD_DATA, 7'h7f, 8'hff, 8'hff, 8'hff, 1'b1);
    send_cmd(CMD_DATA, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_start_conditions();
    wait_drained();
    write_phase_len(10'd0);
    // write of no data; sda low while scl is released means a busy bus
    send_cmd(CMD_BEGIN_W, 7'h7f, 8'hff, 8'h00, 8'h00, 1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_cmd(CMD_BEGIN_R, 7'h00, 8'h00, 8'hff, 8'hff, 1'b0);  // dropped, engine busy
    drive_bus(100000);
    // sda still high after it was pulled low means a bus error
    send_cmd(CMD_BEGIN_R, 7'h00, 8'h00, 8'h01, 8'hff, 1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drive_bus(100000);
  endtask

  task automatic test_write_handoff();
    send_cmd(CMD_BEGIN_W, 7'($urandom_range(127)), 8'($urandom_range(255)), 8'd2, 8'h00,
             1'b0);
    while (bus_phase != PH_WAIT) send_tick(pick_sda());
    send_tick(1'b0);  // ticks while a byte is requested change nothing
    send_tick(1'b1);
    send_cmd(CMD_DATA, 7'h00, 8'h00, 8'h00, 8'hff, 1'b0);
    while (bus_phase != PH_WAIT) send_tick(pick_sda());
    send_cmd(CMD_DATA, 7'h7f, 8'hff, 8'hff, 8'h00, 1'b1);
    drive_bus(100000);
  endtask

  task automatic test_empty_read();
    send_cmd(CMD_BEGIN_R, 7'($urandom_range(127)), 8'($urandom_range(255)), 8'd0, 8'h00,
             1'b1);
    drive_bus(100000);
  endtask

  task automatic test_slow_phase();
    wait_drained();
    write_phase_len(10'd1023);
    send_cmd(CMD_BEGIN_W, 7'($urandom_range(127)), 8'($urandom_range(255)), 8'd1, 8'h00,
             1'b1);
    repeat (30) send_tick(1'($urandom_range(1)));
    // shrinking the phase mid-count ends the current phase at the next tick
    wait_drained();
    write_phase_len(10'd1);
    drive_bus(100000);
  endtask

  task automatic test_backpressure();
    send_cmd(CMD_BEGIN_R, 7'($urandom_range(127)), 8'($urandom_range(255)), 8'd2, 8'h00,
             1'b1);
    hold_target = hold_target + 80;
    repeat (20) send_tick(pick_sda());
    wait_drained();
    drive_bus(100000);
  endtask

  task automatic test_random_traffic(input int budget);
    int base;
    int r;
    logic [7:0] cnt;
    base = n_items;
    while (n_items - base < budget) begin
      if ($urandom_range(4) == 0) begin
        wait_drained();
        case ($urandom_range(5))
          0: write_phase_len(10'd0);
          1, 2: write_phase_len(10'd1);
          3: write_phase_len(10'd2);
          default: write_phase_len(10'd3);
        endcase
      end
      r = $urandom_range(99);
      if (r < 15) cnt = 8'd0;
      else if (r < 80) cnt = 8'($urandom_range(1, 3));
      else cnt = 8'($urandom_range(4, 8));
      send_cmd($urandom_range(1) ? CMD_BEGIN_R : CMD_BEGIN_W, 7'($urandom_range(127)),
               8'($urandom_range(255)), cnt, 8'($urandom_range(255)),
               1'($urandom_range(1)));
      drive_bus(100000);
    end
  endtask

  // long write left open at the end of the run
  task automatic test_long_write();
    send_cmd(CMD_BEGIN_W, 7'h7f, 8'h80, 8'hff, 8'h5a, 1'b1);
    drive_bus(150);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    test_idle_commands();
    test_start_conditions();
    test_write_handoff();
    test_empty_read();
    test_slow_phase();
    test_backpressure();
    send_idle_pct = 23;
    recv_idle_pct = 48;
    test_random_traffic(250);
    send_idle_pct = 48;
    recv_idle_pct = 23;
    test_random_traffic(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(250);
    test_long_write();
    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d commands, %0d results, %0d stops, %0d bytes read back",
             n_items, n_results, n_stops, n_read_bytes);
    $display("phase lengths 0 to 3 and 1023, start faults, hold-off and drain, open write");
    if (err_cnt == 0) begin
      $display("i2c_master_register_access_top: match");
    end else begin
      $display("%0d errors", err_cnt);
      $display("i2c_master_register_access_top: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #8000000;
    $display("i2c_master_register_access_top: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/i2cm_pkg.sv
src/i2cm_front.sv
src/i2cm_engine.sv
src/i2c_master_register_access_top.sv
src/i2cm_checker.sv
tb/sv/tb_i2c_master_register_access_top.sv
